>>> src/mapl_pkg.sv
// Shared types and constants for the moving average peak level block.
package mapl_pkg;

  localparam int LEVEL_W = 16;

  typedef logic [LEVEL_W-1:0] level_t;

  localparam level_t TARGET_LEVEL_RESET = level_t'(16384);

endpackage

>>> src/mapl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module mapl_ram
  import mapl_pkg::*;
#(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/moving_average_peak_level_top.sv
// Top level of the moving average with peak hold on level samples.
//
//   Channel   Direction  Signals                          Content
//   s         in         s_tvalid s_tready s_tdata[15:0]  sample
//   m         out        m_tvalid m_tready m_tdata[15:0]  smoothed_level
//                        m_tuser[0]                       window_full
//   cfg       in         cfg_we cfg_wdata[15:0]           target_level
//
// One request is taken per cycle unless back-pressure fills the stages; each
// result passes through three registered stages. The sample ring sits in a
// RAM whose registered read is issued one request ahead. Reset clears the
// counters, the sum and the peak at once, with no pass over the RAM. A
// stalled output only holds the stages behind it once they are all occupied.
module moving_average_peak_level_top
  import mapl_pkg::*;
#(
  parameter int WINDOW = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [15:0]  s_tdata,   // sample
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [15:0]  m_tdata,   // smoothed_level
  output logic [0:0]   m_tuser,   // window_full
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata  // target_level
);

  localparam int CW     = $clog2(WINDOW);
  localparam int AW     = CW;
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SUM_W  = LEVEL_W + CW;
  localparam int K      = SUM_W + CW;
  localparam logic [63:0] RECIP_WIDE = ((64'd1 << K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [SUM_W:0] RECIP = RECIP_WIDE[SUM_W:0];

  level_t              target_level;
  logic [AW-1:0]       write_slot;
  logic [AW-1:0]       write_slot_next;
  logic [FILL_W-1:0]   fill_count;
  logic [FILL_W-1:0]   fill_count_next;
  logic [SUM_W-1:0]    running_sum;
  logic [SUM_W-1:0]    running_sum_next;
  level_t              peak_mean;
  level_t              peak_mean_next;
  level_t              old_sample;

  logic                v1;
  logic [SUM_W-1:0]    num1;
  logic                full1;
  logic                v2;
  level_t              q2;
  logic                full2;

  logic                ready1;
  logic                ready2;
  logic                ready3;
  logic                accept;
  logic                full_now;
  logic                full_new;
  logic [FILL_W-1:0]   gap_wide;
  logic [CW-1:0]       gap;
  logic [SUM_W-1:0]    pad;
  logic [2*SUM_W:0]    product;

  assign ready3   = !m_tvalid || m_tready;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign s_tready = ready1;
  assign accept   = s_tvalid && ready1;

  always_comb begin
    full_now         = (fill_count == FILL_W'(WINDOW));
    write_slot_next  = write_slot;
    fill_count_next  = fill_count;
    running_sum_next = running_sum;
    if (accept) begin
      write_slot_next = (write_slot == AW'(WINDOW - 1)) ? '0 : write_slot + AW'(1);
      if (!full_now) begin
        fill_count_next = fill_count + FILL_W'(1);
      end
      running_sum_next = running_sum + SUM_W'(s_tdata)
                         - (full_now ? SUM_W'(old_sample) : '0);
    end
    full_new = (fill_count_next == FILL_W'(WINDOW));
    gap_wide = FILL_W'(WINDOW) - fill_count_next;
    gap      = gap_wide[CW-1:0];
    pad      = SUM_W'(target_level) * SUM_W'(gap);
  end

  mapl_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (accept),
    .waddr (write_slot),
    .wdata (s_tdata),
    .raddr (write_slot_next),
    .rdata (old_sample)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      target_level <= TARGET_LEVEL_RESET;
      write_slot   <= '0;
      fill_count   <= '0;
      running_sum  <= '0;
    end else begin
      if (cfg_we) begin
        target_level <= cfg_wdata;
      end
      write_slot  <= write_slot_next;
      fill_count  <= fill_count_next;
      running_sum <= running_sum_next;
    end
  end

  // Stage one: numerator of the blended or full-window mean.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      num1  <= full_new ? running_sum_next : running_sum_next + pad;
      full1 <= full_new;
    end
  end

  // Stage two: division by the window length as a reciprocal multiplication.
  assign product = (2*SUM_W+1)'(num1) * (2*SUM_W+1)'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && v1) begin
      q2    <= product[K +: LEVEL_W];
      full2 <= full1;
    end
  end

  // Stage three: peak hold and the output register.
  always_comb begin
    peak_mean_next = peak_mean;
    if (ready3 && v2 && full2 && (q2 > peak_mean)) begin
      peak_mean_next = q2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid  <= 1'b0;
      peak_mean <= '0;
    end else begin
      peak_mean <= peak_mean_next;
      if (ready3) begin
        m_tvalid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && v2) begin
      m_tdata <= full2 ? peak_mean_next : q2;
      m_tuser <= full2;
    end
  end

endmodule
